/* hdl/npc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_pkg
// Shared types and constants for the nearest palette color search.
// ----------------------------------------------------------------------------
package npc_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned IDX_W  = 5;   // entry index and search count width
  localparam int unsigned SQ_W   = 2 * CHAN_W;
  localparam int unsigned DIST_W = 18;  // 3 * 255^2 fits
  localparam int unsigned ENTRY_W = 3 * CHAN_W;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [IDX_W-1:0] ENTRIES_RESET = 5'd18;
  localparam logic [DIST_W-1:0] DIST_MAX = 18'd195075;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } npc_state_t;

  // Travels alongside each palette entry through the distance pipeline.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] idx;
  } npc_tag_t;

endpackage

/* hdl/npc_dist.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_dist
// Two-stage squared RGB distance: channel squares, then their sum.
// ----------------------------------------------------------------------------
module npc_dist (
  input  logic                          clk,
  input  logic                          rst_n,
  input  npc_pkg::npc_tag_t             tag_in,
  input  logic [npc_pkg::ENTRY_W-1:0]   entry,
  input  logic [npc_pkg::CHAN_W-1:0]    q_red,
  input  logic [npc_pkg::CHAN_W-1:0]    q_green,
  input  logic [npc_pkg::CHAN_W-1:0]    q_blue,
  output npc_pkg::npc_tag_t             tag_out,
  output logic [npc_pkg::DIST_W-1:0]    dist_out
);

  logic [npc_pkg::CHAN_W-1:0] e_red, e_green, e_blue;
  logic [npc_pkg::CHAN_W-1:0] d_red, d_green, d_blue;
  logic [npc_pkg::SQ_W-1:0]   sq_red_r, sq_green_r, sq_blue_r;
  npc_pkg::npc_tag_t          tag_a_r, tag_b_r;
  logic [npc_pkg::DIST_W-1:0] dist_r;

  assign e_red   = entry[3*npc_pkg::CHAN_W-1:2*npc_pkg::CHAN_W];
  assign e_green = entry[2*npc_pkg::CHAN_W-1:npc_pkg::CHAN_W];
  assign e_blue  = entry[npc_pkg::CHAN_W-1:0];

  always_comb begin
    d_red   = (q_red   >= e_red)   ? q_red   - e_red   : e_red   - q_red;
    d_green = (q_green >= e_green) ? q_green - e_green : e_green - q_green;
    d_blue  = (q_blue  >= e_blue)  ? q_blue  - e_blue  : e_blue  - q_blue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r <= '0;
      tag_b_r <= '0;
    end else begin
      tag_a_r <= tag_in;
      tag_b_r <= tag_a_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_red_r   <= npc_pkg::SQ_W'(d_red)   * npc_pkg::SQ_W'(d_red);
    sq_green_r <= npc_pkg::SQ_W'(d_green) * npc_pkg::SQ_W'(d_green);
    sq_blue_r  <= npc_pkg::SQ_W'(d_blue)  * npc_pkg::SQ_W'(d_blue);
    dist_r     <= npc_pkg::DIST_W'(sq_red_r) + npc_pkg::DIST_W'(sq_green_r)
                + npc_pkg::DIST_W'(sq_blue_r);
  end

  assign tag_out  = tag_b_r;
  assign dist_out = dist_r;

endmodule

/* hdl/nearest_palette_color.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color
// Nearest palette entry search by squared Euclidean RGB distance.
// ----------------------------------------------------------------------------
// A load request (in_command = 0) writes one palette entry in the accepting
// cycle; busy stays low and the next request may follow at once. A query
// request (in_command = 1) reads the palette memory one entry per cycle over
// the first N entries (N = the entries_used register, 0 taken as 1, capped at
// PALETTE_SIZE), runs each through a two-stage distance pipeline and keeps the
// best; out_valid is registered from the compare of the last entry, rises as
// busy falls and stays up for one cycle. Busy is high while the entries are
// read and drained through the pipeline, so no new request is taken before the
// result is out. The single memory read port sets the one entry per cycle pace.
// Results are not held: the receiver must take them in the out_valid cycle.
// Ties go to the lowest index. Palette entries hold no defined value until
// loaded, so queries must only reach loaded entries.
// ----------------------------------------------------------------------------
module nearest_palette_color #(
  parameter int unsigned PALETTE_SIZE = 18
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_command,
  input  logic [npc_pkg::IDX_W-1:0]     in_entry_index,
  input  logic [npc_pkg::CHAN_W-1:0]    in_red,
  input  logic [npc_pkg::CHAN_W-1:0]    in_green,
  input  logic [npc_pkg::CHAN_W-1:0]    in_blue,
  output logic                          out_valid,
  output logic [npc_pkg::IDX_W-1:0]     out_nearest_index,
  output logic [npc_pkg::DIST_W-1:0]    out_distance_squared,
  input  logic                          cfg_we,
  input  logic [npc_pkg::IDX_W-1:0]     cfg_data
);

  localparam int unsigned AW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;

  logic [npc_pkg::ENTRY_W-1:0] mem [PALETTE_SIZE];

  npc_pkg::npc_state_t state_r, state_nxt;

  logic [npc_pkg::IDX_W-1:0]  entries_used_r;
  logic [npc_pkg::IDX_W-1:0]  count_r, count_nxt;
  logic [npc_pkg::IDX_W-1:0]  rd_ptr_r;
  logic [npc_pkg::CHAN_W-1:0] q_red_r, q_green_r, q_blue_r;
  logic [npc_pkg::ENTRY_W-1:0] rd_data_r;
  npc_pkg::npc_tag_t          rd_tag_r, cmp_tag;
  logic [npc_pkg::DIST_W-1:0] cmp_dist;
  logic [npc_pkg::DIST_W-1:0] best_dist_r, best_dist_nxt;
  logic [npc_pkg::IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [npc_pkg::IDX_W-1:0]  out_idx_r;
  logic [npc_pkg::DIST_W-1:0] out_dist_r;
  logic                       out_valid_r;

  logic accept, query_go, load_go, rd_en, rd_last;

  assign accept   = start && !busy;
  assign query_go = accept && (in_command == npc_pkg::CMD_QUERY);
  assign load_go  = accept && (in_command == npc_pkg::CMD_LOAD)
                    && (int'(in_entry_index) < int'(PALETTE_SIZE));
  assign rd_last  = (rd_ptr_r == count_r - npc_pkg::IDX_W'(1));

  // Search count: zero searches one entry, too large clips to the palette.
  always_comb begin
    count_nxt = entries_used_r;
    if (entries_used_r == '0) begin
      count_nxt = npc_pkg::IDX_W'(1);
    end else if (int'(entries_used_r) > int'(PALETTE_SIZE)) begin
      count_nxt = npc_pkg::IDX_W'(PALETTE_SIZE);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      npc_pkg::ST_IDLE: begin
        if (query_go) state_nxt = npc_pkg::ST_SCAN;
      end
      npc_pkg::ST_SCAN: begin
        if (rd_last) state_nxt = npc_pkg::ST_DRAIN;
      end
      npc_pkg::ST_DRAIN: begin
        if (cmp_tag.valid && cmp_tag.last) state_nxt = npc_pkg::ST_IDLE;
      end
      default: state_nxt = npc_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    busy  = 1'b1;
    rd_en = 1'b0;
    case (state_r)
      npc_pkg::ST_IDLE:  busy = 1'b0;
      npc_pkg::ST_SCAN:  rd_en = 1'b1;
      npc_pkg::ST_DRAIN: rd_en = 1'b0;
      default:           busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= npc_pkg::ST_IDLE;
      entries_used_r <= npc_pkg::ENTRIES_RESET;
      rd_ptr_r       <= '0;
      rd_tag_r       <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) entries_used_r <= cfg_data;
      if (query_go) begin
        rd_ptr_r <= '0;
      end else if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + npc_pkg::IDX_W'(1);
      end
      rd_tag_r.valid <= rd_en;
      rd_tag_r.first <= (rd_ptr_r == '0);
      rd_tag_r.last  <= rd_last;
      rd_tag_r.idx   <= rd_ptr_r;
      out_valid_r    <= cmp_tag.valid && cmp_tag.last;
    end
  end

  // Query color and search count, held for the whole scan
  always_ff @(posedge clk) begin
    if (query_go) begin
      q_red_r   <= in_red;
      q_green_r <= in_green;
      q_blue_r  <= in_blue;
      count_r   <= count_nxt;
    end
  end

  // Palette memory: writes only while idle, reads only while scanning
  always_ff @(posedge clk) begin
    if (load_go) mem[AW'(in_entry_index)] <= {in_red, in_green, in_blue};
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[AW'(rd_ptr_r)];
  end

  npc_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .tag_in   (rd_tag_r),
    .entry    (rd_data_r),
    .q_red    (q_red_r),
    .q_green  (q_green_r),
    .q_blue   (q_blue_r),
    .tag_out  (cmp_tag),
    .dist_out (cmp_dist)
  );

  // Strict less-than keeps the lowest index on ties
  always_comb begin
    best_dist_nxt = best_dist_r;
    best_idx_nxt  = best_idx_r;
    if (cmp_tag.valid && (cmp_tag.first || (cmp_dist < best_dist_r))) begin
      best_dist_nxt = cmp_dist;
      best_idx_nxt  = cmp_tag.idx;
    end
  end

  always_ff @(posedge clk) begin
    best_dist_r <= best_dist_nxt;
    best_idx_r  <= best_idx_nxt;
    if (cmp_tag.valid && cmp_tag.last) begin
      out_idx_r  <= best_idx_nxt;
      out_dist_r <= best_dist_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_nearest_index    = out_idx_r;
  assign out_distance_squared = out_dist_r;

`ifndef SYNTHESIS
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result issued while still busy");

  a_query_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    query_go |=> busy)
    else $error("query accepted but busy not raised");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_command == npc_pkg::CMD_LOAD)) |=> !busy)
    else $error("load request made the block busy");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_nearest_index < count_r))
    else $error("nearest index beyond search count");

  a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_distance_squared <= npc_pkg::DIST_MAX))
    else $error("distance above maximum");
`endif

endmodule
